@@ rtl/sampler_zone_selector_defines.svh @@
// Assertion macros for the top level of the sampler zone selector RTL.
`ifndef SAMPLER_ZONE_SELECTOR_DEFINES_SVH
`define SAMPLER_ZONE_SELECTOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define SZS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SZS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SZS_ASSERT_IMPL(label, ante, cons)
`define SZS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/szs_pkg.sv @@
// Package with shared types and constants of the sampler zone selector.
package szs_pkg;
  localparam int ZoneSlots = 64;
  localparam int SlotW = 6;
  localparam logic [4:0] NoArt = 5'd16;
  localparam logic [7:0] MaxNote = 8'd127;

  localparam logic [1:0] ActWrite = 2'd0;
  localparam logic [1:0] ActTrigger = 2'd1;
  localparam logic [1:0] ActExplicit = 2'd2;
  localparam logic [1:0] ActUnused = 2'd3;

  localparam logic [3:0] StOk = 4'd0;
  localparam logic [3:0] StBadNote = 4'd1;
  localparam logic [3:0] StBadVel = 4'd2;
  localparam logic [3:0] StUnknownZone = 4'd3;
  localparam logic [3:0] StArtMismatch = 4'd4;
  localparam logic [3:0] StNoDefault = 4'd5;
  localparam logic [3:0] StUnknownArt = 4'd6;
  localparam logic [3:0] StNoMatch = 4'd7;
  localparam logic [3:0] StBadGroup = 4'd8;
  localparam logic [3:0] StZoneArt = 4'd9;
  localparam logic [3:0] StUnmapped = 4'd10;

  typedef struct packed {
    logic [6:0] klo;
    logic [6:0] khi;
    logic [6:0] vlo;
    logic [6:0] vhi;
    logic [6:0] root;
    logic [4:0] art;
    logic [1:0] links;
    logic [7:0] smp;
  } zone_t;

  // Search request held at the top level and compared with each zone that reaches the head.
  typedef struct packed {
    logic [6:0] note;
    logic [6:0] vel;
    logic [4:0] target;
  } search_t;
endpackage

@@ rtl/szs_cell.sv @@
// One cell of the zone chain: holds a zone and its valid bit.
module szs_cell import szs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  zone_t           wr_zone,
  input  logic            shift,
  input  logic            prev_valid,
  input  zone_t           prev_zone,
  output logic            zone_valid,
  output zone_t           zone
);
  logic  valid_r, valid_nxt;
  zone_t zone_r, zone_nxt;

  // The chain rotates during a scan; a write lands in the head cell.
  always_comb begin
    valid_nxt = valid_r;
    zone_nxt = zone_r;
    if (shift) begin
      valid_nxt = prev_valid;
      zone_nxt = prev_zone;
    end else if (wr_en) begin
      valid_nxt = 1'b1;
      zone_nxt = wr_zone;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    zone_r <= zone_nxt;
  end

  assign zone_valid = valid_r;
  assign zone = zone_r;
endmodule

@@ rtl/szs_chain.sv @@
// Ring of zone cells; cell 0 is the head that is read and written.
module szs_chain import szs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift,
  input  logic  wr_en,
  input  zone_t wr_zone,
  output logic  head_valid,
  output zone_t head_zone
);
  logic  v [ZoneSlots];
  zone_t z [ZoneSlots];

  // Each cell takes from its right neighbour, the last from the head.
  for (genvar i = 0; i < ZoneSlots; i++) begin : g_cell
    localparam int Nx = (i + 1) % ZoneSlots;
    szs_cell u_cell (
      .clk(clk), .rst_n(rst_n), .wr_en(wr_en && (i == 0)), .wr_zone(wr_zone),
      .shift(shift), .prev_valid(v[Nx]), .prev_zone(z[Nx]),
      .zone_valid(v[i]), .zone(z[i])
    );
  end

  assign head_valid = v[0];
  assign head_zone = z[0];
endmodule

@@ rtl/sampler_zone_selector.sv @@
// Top level of the sampler zone selector.
// Usage: pulse start with an item while busy is low. action 0 writes a zone
// slot, action 1 resolves a note trigger, action 2 resolves a named slot.
// Zones live in a ring of 64 cells; the head cell holds the slot given by a
// rotation offset. A trigger or a named-slot request rotates the ring once
// round, one zone examined per cycle, before S_DONE raises out_valid. A write
// rotates the ring only until the target slot reaches the head and writes it
// there; how far it turns depends on the current offset. Items that fail the
// note or velocity check, and action 3, go straight to S_DONE. out_valid marks
// each result for one cycle and cannot be held off. Reset clears all valid bits
// and the registers (articulation count 0, default articulation 16).
// The configuration port is APB with pready tied high; registers at 0 and 4.
module sampler_zone_selector import szs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [5:0]  in_slot,
  input  logic [6:0]  in_key_low,
  input  logic [6:0]  in_key_high,
  input  logic [6:0]  in_vel_low,
  input  logic [6:0]  in_vel_high,
  input  logic [6:0]  in_root_key,
  input  logic [4:0]  in_articulation,
  input  logic [1:0]  in_links_ok,
  input  logic [7:0]  in_sample_index,
  input  logic [7:0]  in_midi_note,
  input  logic [7:0]  in_note_velocity,
  output logic        out_valid,
  output logic [3:0]  out_status,
  output logic [5:0]  out_chosen_zone,
  output logic [7:0]  out_chosen_sample,
  output logic [3:0]  out_chosen_articulation,
  output logic        out_used_default,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  `include "sampler_zone_selector_defines.svh"

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t      state_r;
  logic [4:0]  cfg_art_count_r, cfg_default_art_r;
  logic [5:0]  head_slot_r;
  logic [6:0]  cnt_r;
  logic [1:0]  act_r;
  logic [5:0]  slot_r;
  zone_t       wzone_r;
  search_t     srch_r;
  logic [4:0]  req_art_r;
  logic        found_r, used_def_r;
  zone_t       best_r;
  logic [5:0]  best_slot_r;
  logic [3:0]  status_r;
  logic        out_valid_r;
  logic [3:0]  out_status_r;
  logic [5:0]  out_zone_r;
  logic [7:0]  out_sample_r;
  logic [3:0]  out_art_r;
  logic        out_def_r;

  logic        shift, wr_en, head_valid, accept, cfg_wr;
  zone_t       head_zone;

  // Configuration register transfers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    case (paddr[2])
      1'b0:    prdata = {27'd0, cfg_art_count_r};
      default: prdata = {27'd0, cfg_default_art_r};
    endcase
  end

  function automatic logic art_known(input logic [4:0] a, input logic [4:0] cnt);
    art_known = (a < cnt) && (a < NoArt);
  endfunction

  function automatic logic [6:0] udist(input logic [6:0] a, input logic [6:0] b);
    udist = (a > b) ? a - b : b - a;
  endfunction

  // A write holds the ring still for the one cycle in which its slot is at the head.
  assign accept = start && !busy;
  assign busy = (state_r != S_IDLE);
  assign wr_en = (state_r == S_SCAN) && (act_r == ActWrite) && (head_slot_r == slot_r);
  assign shift = (state_r == S_SCAN) && !wr_en;

  szs_chain u_chain (
    .clk(clk), .rst_n(rst_n), .shift(shift), .wr_en(wr_en), .wr_zone(wzone_r),
    .head_valid(head_valid), .head_zone(head_zone)
  );

  // Candidate test and ranking against the best zone so far.
  logic        match, better;
  logic [6:0]  dc, db, kc, kb, vc, vb;
  always_comb begin
    match = head_valid && (head_zone.art == srch_r.target) &&
            (srch_r.note >= head_zone.klo) && (srch_r.note <= head_zone.khi) &&
            (srch_r.vel >= head_zone.vlo) && (srch_r.vel <= head_zone.vhi);
    dc = udist(head_zone.root, srch_r.note);
    db = udist(best_r.root, srch_r.note);
    kc = head_zone.khi - head_zone.klo;
    kb = best_r.khi - best_r.klo;
    vc = head_zone.vhi - head_zone.vlo;
    vb = best_r.vhi - best_r.vlo;
    if (dc != db) better = dc < db;
    else if (kc != kb) better = kc < kb;
    else if (vc != vb) better = vc < vb;
    else better = head_slot_r < best_slot_r;
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cfg_art_count_r <= 5'd0;
      cfg_default_art_r <= NoArt;
      head_slot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr && paddr[2:0] == 3'd0) cfg_art_count_r <= pwdata[4:0];
      if (cfg_wr && paddr[2:0] == 3'd4) cfg_default_art_r <= pwdata[4:0];
      if (shift) head_slot_r <= head_slot_r + 6'd1;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            act_r <= in_action;
            slot_r <= in_slot;
            wzone_r <= '{in_key_low, in_key_high, in_vel_low, in_vel_high, in_root_key,
                         in_articulation, in_links_ok, in_sample_index};
            req_art_r <= in_articulation;
            srch_r.note <= in_midi_note[6:0];
            srch_r.vel <= in_note_velocity[6:0];
            used_def_r <= 1'b0;
            found_r <= 1'b0;
            cnt_r <= '0;
            status_r <= StOk;
            srch_r.target <= in_articulation;
            if (in_action == ActWrite) begin
              state_r <= S_SCAN;
            end else if (in_action == ActUnused) begin
              state_r <= S_DONE;
            end else if (in_midi_note > MaxNote) begin
              status_r <= StBadNote;
              state_r <= S_DONE;
            end else if (in_note_velocity == 8'd0 || in_note_velocity > MaxNote) begin
              status_r <= StBadVel;
              state_r <= S_DONE;
            end else begin
              state_r <= S_SCAN;
              if (in_action == ActTrigger) begin
                if (in_articulation == NoArt) begin
                  if (!art_known(cfg_default_art_r, cfg_art_count_r)) begin
                    status_r <= StNoDefault;
                  end else begin
                    srch_r.target <= cfg_default_art_r;
                    used_def_r <= 1'b1;
                  end
                end else if (!art_known(in_articulation, cfg_art_count_r)) begin
                  status_r <= StUnknownArt;
                end
              end
            end
          end
        end
        S_SCAN: begin
          if (wr_en) begin
            // The write lands in the head cell this cycle.
            state_r <= S_DONE;
          end else begin
            // Trigger: rank each matching zone; explicit: capture the named slot.
            if (act_r == ActTrigger) begin
              if (match && (!found_r || better)) begin
                found_r <= 1'b1;
                best_r <= head_zone;
                best_slot_r <= head_slot_r;
              end
            end else if (head_slot_r == slot_r) begin
              found_r <= head_valid;
              best_r <= head_zone;
              best_slot_r <= head_slot_r;
            end
            cnt_r <= cnt_r + 7'd1;
            if (cnt_r == 7'(ZoneSlots - 1)) state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // Present the result of the item for one cycle.
          state_r <= S_IDLE;
          out_valid_r <= 1'b1;
          out_status_r <= StOk;
          out_zone_r <= '0;
          out_sample_r <= '0;
          out_art_r <= '0;
          out_def_r <= used_def_r;
          if (act_r == ActWrite || act_r == ActUnused) begin
            out_def_r <= 1'b0;
          end else if (status_r != StOk) begin
            out_status_r <= status_r;
          end else if (act_r == ActExplicit && !found_r) begin
            out_status_r <= StUnknownZone;
          end else if (act_r == ActExplicit && req_art_r != NoArt &&
                       req_art_r != best_r.art) begin
            out_status_r <= StArtMismatch;
          end else if (!found_r) begin
            out_status_r <= StNoMatch;
          end else if (!best_r.links[0]) begin
            out_status_r <= StBadGroup;
          end else if (!art_known(best_r.art, cfg_art_count_r)) begin
            out_status_r <= StZoneArt;
          end else if (!best_r.links[1]) begin
            out_status_r <= StUnmapped;
          end else begin
            out_zone_r <= best_slot_r;
            out_sample_r <= best_r.smp;
            out_art_r <= best_r.art[3:0];
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_chosen_zone = out_zone_r;
  assign out_chosen_sample = out_sample_r;
  assign out_chosen_articulation = out_art_r;
  assign out_used_default = out_def_r;

  `SZS_ASSERT_NEXT(a_done_outputs, state_r == S_DONE, out_valid_r)
  `SZS_ASSERT_IMPL(a_busy_no_out, out_valid_r, state_r == S_IDLE)
  `SZS_ASSERT_IMPL(a_ok_only, out_valid_r && out_status_r != StOk, out_zone_r == '0)
endmodule

@@ bench/tb_sampler_zone_selector.sv @@
// Self-checking testbench for the sampler zone selector: writes, triggers, named slots.
module tb_sampler_zone_selector import szs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] AddrArtCount = 3'd0;
  localparam logic [2:0] AddrDefaultArt = 3'd4;
  localparam int WatchdogLimit = 4000;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] slot;
    logic [6:0] klo;
    logic [6:0] khi;
    logic [6:0] vlo;
    logic [6:0] vhi;
    logic [6:0] root;
    logic [4:0] art;
    logic [1:0] links;
    logic [7:0] smp;
    logic [7:0] note;
    logic [7:0] vel;
  } request_t;

  typedef struct packed {
    logic [3:0] status;
    logic [5:0] zone;
    logic [7:0] sample;
    logic [3:0] art;
    logic       used_def;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  request_t req = '0;
  logic out_valid;
  wire answer_t got;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Testbench copy of the zone store and registers.
  zone_t   zones_m [ZoneSlots];
  logic    valid_m [ZoneSlots];
  logic [4:0] art_count_m = 5'd0;
  logic [4:0] default_art_m = NoArt;

  answer_t pending_answers[$];
  int errors = 0;
  int idle_cycles = 0;
  int answers_seen = 0;
  int ok_seen = 0;

  always #4 clk = ~clk;

  sampler_zone_selector u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(req.action), .in_slot(req.slot), .in_key_low(req.klo),
    .in_key_high(req.khi), .in_vel_low(req.vlo), .in_vel_high(req.vhi),
    .in_root_key(req.root), .in_articulation(req.art), .in_links_ok(req.links),
    .in_sample_index(req.smp), .in_midi_note(req.note), .in_note_velocity(req.vel),
    .out_valid(out_valid), .out_status(got.status), .out_chosen_zone(got.zone),
    .out_chosen_sample(got.sample), .out_chosen_articulation(got.art),
    .out_used_default(got.used_def),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic logic art_is_known(logic [4:0] a);
    return a < art_count_m && a < 5'd16;
  endfunction

  function automatic logic [6:0] distance(logic [6:0] a, logic [6:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // True when candidate zone c beats the current pick b for this note.
  function automatic logic zone_beats(zone_t c, zone_t b, logic [6:0] note);
    if (distance(c.root, note) != distance(b.root, note))
      return distance(c.root, note) < distance(b.root, note);
    if ((c.khi - c.klo) != (b.khi - b.klo)) return (c.khi - c.klo) < (b.khi - b.klo);
    return (c.vhi - c.vlo) < (b.vhi - b.vlo);
  endfunction

  // Works out the answer to one request and updates the zone store.
  function automatic answer_t resolve_zone(request_t r);
    answer_t a;
    logic found;
    int pick;
    logic [4:0] target;
    zone_t z;
    a = '0;
    found = 1'b0;
    pick = 0;
    target = r.art;
    if (r.action == ActWrite) begin
      zones_m[r.slot] = '{r.klo, r.khi, r.vlo, r.vhi, r.root, r.art, r.links, r.smp};
      valid_m[r.slot] = 1'b1;
      return a;
    end
    if (r.action == ActUnused) return a;
    if (r.note > MaxNote) a.status = StBadNote;
    else if (r.vel == 8'd0 || r.vel > MaxNote) a.status = StBadVel;
    else if (r.action == ActExplicit) begin
      if (!valid_m[r.slot]) a.status = StUnknownZone;
      else if (r.art != NoArt && r.art != zones_m[r.slot].art) a.status = StArtMismatch;
      else begin
        found = 1'b1;
        pick = r.slot;
      end
    end else begin
      if (target == NoArt) begin
        if (!art_is_known(default_art_m)) a.status = StNoDefault;
        else begin
          target = default_art_m;
          a.used_def = 1'b1;
        end
      end else if (!art_is_known(target)) a.status = StUnknownArt;
      if (a.status == StOk) begin
        for (int i = 0; i < ZoneSlots; i++) begin
          z = zones_m[i];
          if (valid_m[i] && z.art == target && r.note >= z.klo && r.note <= z.khi &&
              r.vel >= z.vlo && r.vel <= z.vhi &&
              (!found || zone_beats(z, zones_m[pick], r.note[6:0]))) begin
            found = 1'b1;
            pick = i;
          end
        end
        if (!found) a.status = StNoMatch;
      end
    end
    if (a.status == StOk && found) begin
      z = zones_m[pick];
      if (!z.links[0]) a.status = StBadGroup;
      else if (!art_is_known(z.art)) a.status = StZoneArt;
      else if (!z.links[1]) a.status = StUnmapped;
      else begin
        a.zone = 6'(pick);
        a.sample = z.smp;
        a.art = z.art[3:0];
      end
    end
    return a;
  endfunction

  // Result checker: every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $error("result with nothing expected: status %0d", got.status);
        errors++;
      end else begin
        e = pending_answers.pop_front();
        if (got.status == StOk) ok_seen++;
        if (got.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, got.status); errors++;
        end
        if (got.zone !== e.zone) begin
          $error("chosen_zone expected %0d actual %0d", e.zone, got.zone); errors++;
        end
        if (got.sample !== e.sample) begin
          $error("chosen_sample expected %0d actual %0d", e.sample, got.sample); errors++;
        end
        if (got.art !== e.art) begin
          $error("chosen_articulation expected %0d actual %0d", e.art, got.art); errors++;
        end
        if (got.used_def !== e.used_def) begin
          $error("used_default expected %0d actual %0d", e.used_def, got.used_def);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no request, result or register transfer.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sends one request, after a random gap when gaps is set, and records its expected answer.
  task automatic send_request(request_t r, bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    // The block is always busy for the cycle after a transfer, so the first
    // falling edge costs no throughput.
    repeat (gap + 1) @(negedge clk);
    req <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_answers.push_back(resolve_zone(r));
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Waits until every answer has arrived and the block has gone quiet.
  task automatic drain();
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // Register write over the APB port; only used while the block is idle.
  task automatic write_reg(logic [2:0] addr, logic [4:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= {$urandom} & ~32'h1f | value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrArtCount) art_count_m = value;
    else default_art_m = value;
  endtask

  function automatic request_t random_request();
    request_t r;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    r = raw[$bits(request_t)-1:0];
    r.action = 2'($urandom_range(0, 3));
    r.art = 5'($urandom_range(0, 16));
    r.note = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                                           8'($urandom_range(0, 127));
    r.vel = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                                          8'($urandom_range(1, 127));
    if (r.action == ActExplicit && !valid_m[r.slot]) r.action = ActTrigger;
    return r;
  endfunction

  // Zone write with a sensible key and velocity range and a random root, for a dense table.
  function automatic request_t zone_write(int slot, int arts);
    request_t r;
    r = random_request();
    r.action = ActWrite;
    r.slot = 6'(slot);
    r.klo = 7'($urandom_range(0, 100));
    r.khi = 7'(r.klo + $urandom_range(0, 27));
    r.vlo = 7'($urandom_range(0, 90));
    r.vhi = 7'(r.vlo + $urandom_range(0, 37));
    r.root = 7'($urandom_range(0, 127));
    r.art = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(0, 16)) :
                                           5'($urandom_range(0, arts - 1));
    r.links = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) : 2'd3;
    return r;
  endfunction

  // Directed edge cases: field extremes, each status and each action.
  task automatic test_directed();
    request_t r;
    write_reg(AddrArtCount, 5'd4);
    write_reg(AddrDefaultArt, 5'd1);
    r = '0; r.note = 8'd60; r.vel = 8'd64; r.art = NoArt; r.action = ActTrigger;
    send_request(r);                       // no zones yet: no match
    r = '{ActWrite, 6'd0, 7'd0, 7'd127, 7'd1, 7'd127, 7'd60, 5'd1, 2'd3, 8'd255, 8'd0, 8'd0};
    send_request(r);
    r = '{ActWrite, 6'd63, 7'd50, 7'd70, 7'd1, 7'd127, 7'd60, 5'd1, 2'd3, 8'd7, 8'd0, 8'd0};
    send_request(r);
    r = '{ActWrite, 6'd5, 7'd60, 7'd60, 7'd64, 7'd64, 7'd60, 5'd2, 2'd1, 8'd9, 8'd0, 8'd0};
    send_request(r);
    r = '{ActWrite, 6'd6, 7'd0, 7'd127, 7'd0, 7'd127, 7'd0, 5'd3, 2'd2, 8'd1, 8'd0, 8'd0};
    send_request(r);
    r = '{ActWrite, 6'd7, 7'd0, 7'd127, 7'd0, 7'd127, 7'd0, 5'd15, 2'd3, 8'd1, 8'd0, 8'd0};
    send_request(r);
    r = '0; r.action = ActTrigger; r.art = NoArt; r.note = 8'd60; r.vel = 8'd64;
    send_request(r);                       // default used, narrower zone wins
    r.note = 8'd128; send_request(r);      // bad note
    r.note = 8'd255; send_request(r);
    r.note = 8'd127; r.vel = 8'd0; send_request(r);   // bad velocity
    r.vel = 8'd128; send_request(r);
    r.vel = 8'd127; send_request(r);
    r.art = 5'd2; r.note = 8'd60; r.vel = 8'd64; send_request(r);   // sample unmapped
    r.art = 5'd3; send_request(r);         // bad group
    r.art = 5'd9; send_request(r);         // unknown articulation
    r.action = ActExplicit; r.slot = 6'd7; r.art = NoArt;
    send_request(r);                       // zone articulation unknown
    r.art = 5'd1; send_request(r);         // mismatch
    r.slot = 6'd9; send_request(r);        // unknown zone
    r.slot = 6'd63; send_request(r);       // ok
    r.action = ActUnused; send_request(r); // unused action
    drain();
    write_reg(AddrDefaultArt, NoArt);
    r = '0; r.action = ActTrigger; r.art = NoArt; r.note = 8'd1; r.vel = 8'd1;
    send_request(r);                       // no default
    drain();
  endtask

  // Random phases across register settings including both extremes.
  task automatic test_random_phases();
    int settings[5] = '{16, 0, 1, 8, 16};
    int arts;
    for (int p = 0; p < 5; p++) begin
      arts = (settings[p] == 0) ? 1 : settings[p];
      write_reg(AddrArtCount, 5'(settings[p]));
      write_reg(AddrDefaultArt, (p == 1) ? 5'd0 : 5'($urandom_range(0, 16)));
      for (int i = 0; i < 24; i++) send_request(zone_write($urandom_range(0, 63), arts));
      for (int i = 0; i < 300; i++) begin
        if ($urandom_range(0, 9) == 0) send_request(zone_write($urandom_range(0, 63), arts));
        else send_request(random_request(), p != 2);
      end
      // Pause until everything has come back before the registers change.
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < ZoneSlots; i++) begin
      zones_m[i] = '0;
      valid_m[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_phases();
    $display("Covered %0d results (%0d resolved ok) across zone writes, triggers and",
             answers_seen, ok_seen);
    $display("named-slot requests under several articulation count and default settings.");
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/szs_pkg.sv
rtl/szs_cell.sv
rtl/szs_chain.sv
rtl/sampler_zone_selector.sv
bench/tb_sampler_zone_selector.sv
